FILE: rtl/pst_pkg.sv
// Shared types, register map and reset constants of the pump shot timer.
package pst_pkg;

    // Configuration register map
    localparam int unsigned CFG_NUM_REGS = 3;
    localparam int unsigned CFG_ADDR_W   = 4;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned TIME_W       = 32;

    localparam logic [1:0] REG_STOP_HOLDOFF  = 2'd0;
    localparam logic [1:0] REG_DISP_OFF_DLY  = 2'd1;
    localparam logic [1:0] REG_MIN_SHOT      = 2'd2;

    // Register reset values in milliseconds
    localparam logic [TIME_W-1:0] RST_STOP_HOLDOFF = 32'd1500;
    localparam logic [TIME_W-1:0] RST_DISP_OFF_DLY = 32'd10000;
    localparam logic [TIME_W-1:0] RST_MIN_SHOT     = 32'd15000;

    // Timestamp value that marks a stop or end time as unset
    localparam logic [TIME_W-1:0] TIME_UNSET = '0;

    // One sensor sample request
    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              reed_level;
        logic              display_awake;
    } t_sample;

    // One result request
    typedef struct packed {
        logic              pump_running;
        logic [TIME_W-1:0] shot_start_ms;
        logic [TIME_W-1:0] last_shot_ms;
        logic              sleep_display;
    } t_result;

    // Configuration values handed to the timer core
    typedef struct packed {
        logic [TIME_W-1:0] stop_holdoff_ms;
        logic [TIME_W-1:0] display_off_delay_ms;
        logic [TIME_W-1:0] min_shot_ms;
    } t_cfg;

endpackage

FILE: rtl/pst_stream_if.sv
// Valid/ready stream interface that carries one request per handshake.
interface pst_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/pump_shot_timer_core.sv
// Top level of the pump shot timer.
//
// Sample requests (now_ms, reed_level, display_awake) enter on i_sample, a
// valid/ready stream. Each accepted sample gives exactly one result request on
// o_result: pump_running, shot_start_ms, last_shot_ms and sleep_display, taken
// from the timer state after that sample.
// A sample accepted on i_sample is held in the input register and written to
// the result register with the updated state, where it shows as a valid result.
// Throughput is one sample per cycle while the receiver takes results.
// When the receiver stalls, the result register holds its request and the
// input register can still take one more sample; i_sample.ready then drops.
// The APB port holds stop_holdoff_ms, display_off_delay_ms and min_shot_ms at
// byte addresses 0, 4 and 8. The user writes it only while the block is idle;
// the block itself does not enforce this. Synchronous reset clears both
// pipeline stages, returns the timer to idle with all times unset and loads
// the registers with 1500, 10000 and 15000 ms.
module pump_shot_timer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pst_stream_if.sink                        i_sample,
    pst_stream_if.source                      o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pst_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pst_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pst_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import pst_pkg::*;

    t_cfg w_cfg;

    // Configuration registers
    pst_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Timer datapath
    pst_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_sample (i_sample),
        .o_result (o_result)
    );

    // Reset empties the result stage.
    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid after reset");

    // A hold-off write shows up in the configuration seen by the core.
    a_holdoff_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1:2] == REG_STOP_HOLDOFF)
        |=> w_cfg.stop_holdoff_ms == $past(pwdata))
        else $error("hold-off register not written");

    // A sleep request only follows a shot longer than the minimum.
    a_sleep_needs_long_shot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.sleep_display)
        |-> o_result.data.last_shot_ms > w_cfg.min_shot_ms)
        else $error("sleep request after a short shot");

endmodule

FILE: rtl/pst_cfg_regs.sv
// APB-style configuration registers of the pump shot timer.
module pst_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pst_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [pst_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [pst_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output pst_pkg::t_cfg                     o_cfg
);
    import pst_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[CFG_ADDR_W-1:2];

    // Register write at the access phase; unmapped addresses are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_holdoff_ms      <= RST_STOP_HOLDOFF;
            r_cfg.display_off_delay_ms <= RST_DISP_OFF_DLY;
            r_cfg.min_shot_ms          <= RST_MIN_SHOT;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STOP_HOLDOFF: r_cfg.stop_holdoff_ms      <= pwdata;
                REG_DISP_OFF_DLY: r_cfg.display_off_delay_ms <= pwdata;
                REG_MIN_SHOT:     r_cfg.min_shot_ms          <= pwdata;
                default: ;
            endcase
        end
    end

    // Read data follows the address.
    always_comb begin
        unique case (w_idx)
            REG_STOP_HOLDOFF: prdata = r_cfg.stop_holdoff_ms;
            REG_DISP_OFF_DLY: prdata = r_cfg.display_off_delay_ms;
            REG_MIN_SHOT:     prdata = r_cfg.min_shot_ms;
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/pst_core.sv
// Shot timer core: input register, state update and result register.
module pst_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pst_pkg::t_cfg   i_cfg,
    pst_stream_if.sink      i_sample,
    pst_stream_if.source    o_result
);
    import pst_pkg::*;

    // Pipeline registers
    logic              r_in_vld;
    t_sample           r_in;
    logic              r_out_vld;
    t_result           r_out;

    // Timer state
    logic              r_run;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_stop;
    logic [TIME_W-1:0] r_end;
    logic [TIME_W-1:0] r_len;

    logic              n_run;
    logic [TIME_W-1:0] n_start;
    logic [TIME_W-1:0] n_stop;
    logic [TIME_W-1:0] n_end;
    logic [TIME_W-1:0] n_len;

    logic              w_fire;
    logic              w_start_shot;
    logic              w_stop_path;
    logic [TIME_W-1:0] w_seen;
    logic              w_held;
    logic              w_ending;
    logic              w_sleep;

    // Handshake: the input stage moves on whenever the result stage can take it.
    assign w_fire         = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_sample.ready = !r_in_vld || w_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_sample.ready) begin
            r_in_vld <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in <= i_sample.data;
        end
    end

    // A low level while idle starts a shot; a high level while running arms the stop.
    assign w_start_shot = !r_run && !r_in.reed_level;
    assign w_stop_path  = r_run && r_in.reed_level;
    assign w_seen       = (r_stop == TIME_UNSET) ? r_in.now_ms : r_stop;
    assign w_held       = (r_in.now_ms - w_seen) > i_cfg.stop_holdoff_ms;
    assign w_ending     = w_stop_path && w_held;

    always_comb begin
        n_run   = r_run;
        n_start = r_start;
        n_stop  = TIME_UNSET;
        n_end   = r_end;
        n_len   = r_len;
        if (w_start_shot) begin
            n_run   = 1'b1;
            n_start = r_in.now_ms;
        end
        if (w_ending) begin
            n_run = 1'b0;
            n_end = r_in.now_ms;
            n_len = r_in.now_ms - r_start;
        end else if (w_stop_path) begin
            n_stop = w_seen;
        end
    end

    // A shot that ends in this step has an elapsed time of zero, so no sleep.
    assign w_sleep = r_in.display_awake && !w_ending
                     && (r_len > i_cfg.min_shot_ms)
                     && (r_end != TIME_UNSET)
                     && ((r_in.now_ms - r_end) > i_cfg.display_off_delay_ms);

    // State update on each processed sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_start <= '0;
            r_stop  <= TIME_UNSET;
            r_end   <= TIME_UNSET;
            r_len   <= '0;
        end else if (w_fire) begin
            r_run   <= n_run;
            r_start <= n_start;
            r_stop  <= n_stop;
            r_end   <= n_end;
            r_len   <= n_len;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out.pump_running  <= n_run;
            r_out.shot_start_ms <= n_start;
            r_out.last_shot_ms  <= n_len;
            r_out.sleep_display <= w_sleep;
        end
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

endmodule

FILE: tb/tb_pump_shot_timer_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for pump_shot_timer_core with directed and random sample requests.
module tb_pump_shot_timer_core;
    import pst_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned DRAIN_CYCLES = 4;
    // Index past the end of the register map; writes there must be ignored.
    localparam logic [1:0]  REG_UNUSED   = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Stream sides driven by the testbench.
    logic    send_valid = 1'b0;
    t_sample send_data  = '0;
    logic    take_ready = 1'b0;

    pst_stream_if #(.T(t_sample)) sample_if ();
    pst_stream_if #(.T(t_result)) result_if ();

    assign sample_if.valid = send_valid;
    assign sample_if.data  = send_data;
    assign result_if.ready = take_ready;

    pump_shot_timer_core u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Register values as the block should hold them.
    logic [TIME_W-1:0] cfg_holdoff   = RST_STOP_HOLDOFF;
    logic [TIME_W-1:0] cfg_off_delay = RST_DISP_OFF_DLY;
    logic [TIME_W-1:0] cfg_min_shot  = RST_MIN_SHOT;

    // Shot timer state as the block should hold it after reset.
    logic              pred_running   = 1'b0;
    logic [TIME_W-1:0] pred_start     = '0;
    logic [TIME_W-1:0] pred_stop_seen = TIME_UNSET;
    logic [TIME_W-1:0] pred_end       = TIME_UNSET;
    logic [TIME_W-1:0] pred_length    = '0;

    t_sample pending_samples[$];
    t_result expected_results[$];

    int unsigned       queued_samples = 0;
    int unsigned       error_count    = 0;
    int unsigned       cycle_count    = 0;
    int unsigned       idle_odds      = 4;
    int unsigned       send_gap       = 0;
    int unsigned       recv_gap       = 0;
    logic [TIME_W-1:0] clock_ms       = '0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Advance the shot timer by one sample and return the result it gives.
    function automatic t_result timer_update(input t_sample s);
        t_result           r;
        logic [TIME_W-1:0] held_ms;
        logic [TIME_W-1:0] since_end_ms;
        if (!pred_running && !s.reed_level) begin
            pred_start   = s.now_ms;
            pred_running = 1'b1;
        end
        if (pred_running && s.reed_level) begin
            if (pred_stop_seen == TIME_UNSET) begin
                pred_stop_seen = s.now_ms;
            end
            held_ms = s.now_ms - pred_stop_seen;
            if (held_ms > cfg_holdoff) begin
                pred_running   = 1'b0;
                pred_stop_seen = TIME_UNSET;
                pred_end       = s.now_ms;
                pred_length    = s.now_ms - pred_start;
            end
        end else begin
            pred_stop_seen = TIME_UNSET;
        end
        since_end_ms = s.now_ms - pred_end;
        r.pump_running  = pred_running;
        r.shot_start_ms = pred_start;
        r.last_shot_ms  = pred_length;
        r.sleep_display = s.display_awake && (pred_length > cfg_min_shot) &&
                          (pred_end != TIME_UNSET) && (since_end_ms > cfg_off_delay);
        return r;
    endfunction

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            flag_error($sformatf("%s mismatch: expected %0h, got %0h", name, want, got));
        end
    endtask

    task automatic push_sample(input logic [TIME_W-1:0] now, input logic reed,
                               input logic awake);
        t_sample s;
        s.now_ms        = now;
        s.reed_level    = reed;
        s.display_awake = awake;
        pending_samples.push_back(s);
        clock_ms = now;
        queued_samples++;
    endtask

    // One pump cycle: optional idle samples, a low stretch with an optional
    // bounce, a high stretch that may reach the stop, and a tail for the sleep check.
    task automatic gen_shot(input int unsigned step);
        repeat ($urandom_range(0, 2))
            push_sample(clock_ms + $urandom_range(0, step), 1'b1, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 10))
            push_sample(clock_ms + $urandom_range(0, step), 1'b0, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3))
                push_sample(clock_ms + $urandom_range(0, step), 1'b1, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3))
                push_sample(clock_ms + $urandom_range(0, step), 1'b0, 1'($urandom_range(0, 1)));
        end
        repeat ($urandom_range(1, 8))
            push_sample(clock_ms + $urandom_range(0, step), 1'b1, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(1, 6))
            push_sample(clock_ms + $urandom_range(0, step), 1'b1, $urandom_range(0, 3) != 0);
    endtask

    task automatic gen_noise();
        repeat ($urandom_range(1, 4))
            push_sample($urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_STOP_HOLDOFF: cfg_holdoff   = value;
            REG_DISP_OFF_DLY: cfg_off_delay = value;
            REG_MIN_SHOT:     cfg_min_shot  = value;
            default: ;
        endcase
    endtask

    // Read a register back; prdata is taken mid-cycle in the access phase.
    task automatic cfg_read_check(input logic [1:0] idx);
        logic [CFG_DATA_W-1:0] got;
        logic [CFG_DATA_W-1:0] want;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_STOP_HOLDOFF: want = cfg_holdoff;
            REG_DISP_OFF_DLY: want = cfg_off_delay;
            REG_MIN_SHOT:     want = cfg_min_shot;
            default:          want = '0;
        endcase
        check_field($sformatf("register %0d readback", idx), want, got);
    endtask

    task automatic wait_drain();
        while (pending_samples.size() != 0 || send_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Program one register setting, then run random pump cycles under it.
    task automatic run_phase(input logic [TIME_W-1:0] holdoff, input logic [TIME_W-1:0] off_delay,
                             input logic [TIME_W-1:0] min_shot, input int unsigned step,
                             input int unsigned target, input int unsigned odds);
        int unsigned first;
        cfg_write(REG_STOP_HOLDOFF, holdoff);
        cfg_write(REG_DISP_OFF_DLY, off_delay);
        cfg_write(REG_MIN_SHOT, min_shot);
        cfg_write(REG_UNUSED, $urandom());
        cfg_read_check(REG_STOP_HOLDOFF);
        cfg_read_check(REG_DISP_OFF_DLY);
        cfg_read_check(REG_MIN_SHOT);
        idle_odds = odds;
        first = queued_samples;
        while (queued_samples - first < target) begin
            if ($urandom_range(0, 6) == 0) begin
                gen_noise();
            end else begin
                gen_shot(step);
            end
        end
        wait_drain();
    endtask

    // Sample request driver: holds each request until it is taken.
    always @(posedge i_clk) begin : sample_driver
        logic    next_valid;
        t_sample next_data;
        next_valid = send_valid;
        next_data  = send_data;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (send_valid && sample_if.ready) begin
                expected_results.push_back(timer_update(send_data));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                    send_gap = $urandom_range(0, 7);
                end else if (pending_samples.size() != 0) begin
                    next_valid = 1'b1;
                    next_data  = pending_samples.pop_front();
                end
            end
        end
        send_valid <= next_valid;
        send_data  <= next_data;
    end

    // Result monitor: checks each result request against the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            take_ready <= 1'b0;
        end else begin
            if (result_if.valid && take_ready) begin
                got = result_if.data;
                if (expected_results.size() == 0) begin
                    flag_error($sformatf("result with no sample pending: %0h %0h %0h %0h",
                                         got.pump_running, got.shot_start_ms,
                                         got.last_shot_ms, got.sleep_display));
                end else begin
                    want = expected_results.pop_front();
                    check_field("pump_running", 32'(want.pump_running), 32'(got.pump_running));
                    check_field("shot_start_ms", want.shot_start_ms, got.shot_start_ms);
                    check_field("last_shot_ms", want.last_shot_ms, got.last_shot_ms);
                    check_field("sleep_display", 32'(want.sleep_display),
                                32'(got.sleep_display));
                end
            end
            if (recv_gap != 0) begin
                recv_gap--;
                take_ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                recv_gap = $urandom_range(0, 7);
                take_ready <= 1'b0;
            end else begin
                take_ready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers must come out of reset with their default values.
        cfg_read_check(REG_STOP_HOLDOFF);
        cfg_read_check(REG_DISP_OFF_DLY);
        cfg_read_check(REG_MIN_SHOT);

        // Directed requests under the default setting.
        push_sample(32'd0, 1'b1, 1'b1);
        push_sample(32'd5, 1'b0, 1'b0);
        // Stop first seen at time zero is stored as unset and taken again.
        push_sample(32'd0, 1'b1, 1'b1);
        push_sample(32'd1000, 1'b1, 1'b1);
        // High level held exactly the hold-off does not stop, one more does.
        push_sample(32'd2500, 1'b1, 1'b1);
        push_sample(32'd2501, 1'b1, 1'b1);
        // Long shot starting just before the timestamp wraps.
        push_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
        push_sample(32'h0000_8000, 1'b1, 1'b1);
        // A low sample clears the pending stop.
        push_sample(32'h0000_85DD, 1'b0, 1'b1);
        push_sample(32'h0000_9000, 1'b1, 1'b1);
        push_sample(32'h0000_95DD, 1'b1, 1'b1);
        // Sleep request right at and just past the off delay, then display asleep.
        push_sample(32'h0000_95DD + 32'd10000, 1'b1, 1'b1);
        push_sample(32'h0000_95DD + 32'd10001, 1'b1, 1'b1);
        push_sample(32'h0000_95DD + 32'd10001, 1'b1, 1'b0);
        // A shot ending at time zero never requests sleep.
        push_sample(32'hFFFF_0000, 1'b0, 1'b1);
        push_sample(32'hFFFF_F000, 1'b1, 1'b1);
        push_sample(32'd0, 1'b1, 1'b1);
        push_sample(32'd20000, 1'b1, 1'b1);
        // Start from idle; the stop cannot come in the same step.
        push_sample(32'd100, 1'b0, 1'b0);
        push_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
        push_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
        wait_drain();

        // Random pump cycles under several settings, extremes included.
        run_phase(32'd100, 32'd300, 32'd500, 200, 110, 4);
        run_phase(32'd0, 32'd0, 32'd0, 40, 100, 3);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h4000_0000, 60, 10);
        run_phase($urandom_range(0, 5000), $urandom_range(0, 5000), $urandom_range(0, 5000),
                  2500, 140, 6);
        run_phase(RST_STOP_HOLDOFF, RST_DISP_OFF_DLY, RST_MIN_SHOT, 4000, 140, 0);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
